@@ rtl/core/crt_pkg.sv @@
// shared types and constants for the crt vector pack/unpack core
`default_nettype none
package crt_pkg;

    localparam int MAX_DIMS = 5;
    localparam int MOD_W    = 12;
    localparam int RES_W    = 60;
    localparam int VAL_W    = 63;
    localparam int ADDR_W   = 5;

    localparam logic [2:0] REG_DIMS = 3'd5;

    typedef struct packed {
        logic             mode;
        logic [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic             kind;
        logic [2:0]       slot;
        logic [RES_W-1:0] result;
        logic             final_res;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DSTART,
        S_DMUL,
        S_DSTEP,
        S_DRED,
        S_EUC,
        S_EDIV,
        S_EUPD,
        S_RED,
        S_PMUL,
        S_PSUM,
        S_ULANE,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_Q,
        PH_PART,
        PH_COEF
    } t_phase;

endpackage
`default_nettype wire

@@ rtl/core/crt_vector_pack_unpack_core.sv @@
// crt vector pack/unpack core: bit-serial derivation, reduction and modular multiply
//
// usage: input words (mode, value) arrive on i_in_valid / o_in_stall, results leave on
// o_out_valid / i_out_stall through one output register. moduli and dims_in_use sit
// behind an apb-style port (register i at byte address 4*i, pready always high).
// after reset and after each register write a sequencer derives Q and the coefficients
// bit-serially through 12-bit multiplies, modulus reductions and euclid steps, and
// o_in_stall stays high meanwhile.
// a pack word is first reduced mod Q serially, then goes through double-and-add
// (two half steps per multiplier bit) and one summing step;
// the n-th word of a run leaves one packed word.
// an unpack word is reduced mod Q, then five remainder lanes run in parallel, then
// the n residues leave one per cycle while the output is not stalled.
// a new word is taken only in idle; a finished result may still wait in the output
// register meanwhile. a stalled output word holds, and the core waits before loading
// the next one. reset restores the default moduli and restarts derivation.
`default_nettype none
module crt_vector_pack_unpack_core (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  crt_pkg::t_in_word             i_in_data,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output crt_pkg::t_out_word            o_out_data,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [crt_pkg::ADDR_W-1:0]    paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int MW = crt_pkg::MOD_W;
    localparam int RW = crt_pkg::RES_W;
    localparam int VW = crt_pkg::VAL_W;
    localparam int ND = crt_pkg::MAX_DIMS;

    crt_pkg::t_state r_state, n_state;
    crt_pkg::t_phase r_phase, n_phase;

    logic [MW-1:0] r_mod [ND];
    logic [MW-1:0] n_mod [ND];
    logic [2:0]    r_dims, n_dims;
    logic [RW-1:0] r_q, n_q;
    logic [RW-1:0] r_coef [ND];
    logic [RW-1:0] n_coef [ND];
    logic [RW-1:0] r_sum, n_sum;
    logic [2:0]    r_cnt_el, n_cnt_el;
    logic [2:0]    r_i, n_i;
    logic [2:0]    r_j, n_j;
    logic [RW-1:0] r_a, n_a;
    logic [MW-1:0] r_b, n_b;
    logic [RW-1:0] r_p, n_p;
    logic [5:0]    r_bit, n_bit;
    logic [MW-1:0] r_r0, n_r0;
    logic [MW-1:0] r_r1, n_r1;
    logic signed [13:0] r_s0, n_s0;
    logic signed [13:0] r_s1, n_s1;
    logic [MW-1:0] r_dq, n_dq;
    logic [MW-1:0] r_dr, n_dr;
    logic [VW-1:0] r_v, n_v;
    logic          r_mode, n_mode;
    logic [MW-1:0] r_lane [ND];
    logic [MW-1:0] n_lane [ND];
    logic          r_sub, n_sub;
    logic [RW-1:0] r_alpha, n_alpha;
    logic [2:0]    r_slot, n_slot;
    crt_pkg::t_out_word r_out, n_out;
    logic          r_ovalid, n_ovalid;

    logic          w_cfg_wr;
    logic [2:0]    w_cfg_idx;
    logic [2:0]    w_n;
    logic [RW:0]   w_rin;
    logic [RW-1:0] w_rout;
    logic [RW-1:0] w_mul;
    logic          w_out_free;

    function automatic logic [MW-1:0] mod_eff(input logic [MW-1:0] m);
        mod_eff = (m == '0) ? {{(MW-1){1'b0}}, 1'b1} : m;
    endfunction

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_cfg_idx  = paddr[4:2];
    assign o_in_stall = (r_state != crt_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_ovalid || !i_out_stall;

    always_comb begin
        if (r_dims == 3'd0) begin
            w_n = 3'd1;
        end else if (r_dims > 3'(ND)) begin
            w_n = 3'(ND);
        end else begin
            w_n = r_dims;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_cfg_idx < 3'(ND)) begin
            prdata = {{(32-MW){1'b0}}, r_mod[w_cfg_idx]};
        end else if (w_cfg_idx == crt_pkg::REG_DIMS) begin
            prdata = {29'd0, r_dims};
        end
    end

    // shared compare-and-subtract against Q
    assign w_rout = (w_rin >= {1'b0, r_q}) ? RW'(w_rin - {1'b0, r_q}) : w_rin[RW-1:0];
    // one step of the serial multiplier
    assign w_mul  = {r_p[RW-2:0], 1'b0} + (r_b[MW-1] ? r_a : '0);

    always_comb begin
        unique case (r_state)
            crt_pkg::S_RED:  w_rin = {r_p, r_v[VW-1]};
            crt_pkg::S_PMUL: w_rin = r_sub ? ({1'b0, r_p} + {1'b0, r_a}) : {r_p, 1'b0};
            default:         w_rin = {1'b0, r_sum} + {1'b0, r_p};
        endcase
    end

    always_comb begin
        logic [MW:0]        t13;
        logic signed [27:0] prod;
        logic signed [13:0] inv;
        logic signed [13:0] m14;
        logic [MW-1:0]      mi;
        n_state  = r_state;
        n_phase  = r_phase;
        n_mod    = r_mod;
        n_dims   = r_dims;
        n_q      = r_q;
        n_coef   = r_coef;
        n_sum    = r_sum;
        n_cnt_el = r_cnt_el;
        n_i      = r_i;
        n_j      = r_j;
        n_a      = r_a;
        n_b      = r_b;
        n_p      = r_p;
        n_bit    = r_bit;
        n_r0     = r_r0;
        n_r1     = r_r1;
        n_s0     = r_s0;
        n_s1     = r_s1;
        n_dq     = r_dq;
        n_dr     = r_dr;
        n_v      = r_v;
        n_mode   = r_mode;
        n_lane   = r_lane;
        n_sub    = r_sub;
        n_alpha  = r_alpha;
        n_slot   = r_slot;
        n_out    = r_out;
        n_ovalid = r_ovalid && i_out_stall;
        mi       = mod_eff(r_mod[r_i]);
        m14      = $signed({2'b00, mi});
        t13      = '0;
        prod     = '0;
        inv      = '0;

        unique case (r_state)
            crt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_in_data.mode;
                    n_v     = i_in_data.value;
                    n_p     = '0;
                    n_bit   = '0;
                    n_state = crt_pkg::S_RED;
                end
            end
            crt_pkg::S_DSTART: begin
                n_phase  = crt_pkg::PH_Q;
                n_i      = '0;
                n_j      = '0;
                n_a      = RW'(1);
                n_b      = mod_eff(r_mod[0]);
                n_p      = '0;
                n_bit    = '0;
                n_sum    = '0;
                n_cnt_el = '0;
                n_state  = crt_pkg::S_DMUL;
            end
            crt_pkg::S_DMUL: begin
                n_p   = w_mul;
                n_b   = {r_b[MW-2:0], 1'b0};
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'(MW-1)) begin
                    n_a     = w_mul;
                    n_p     = '0;
                    n_bit   = '0;
                    n_state = crt_pkg::S_DSTEP;
                end
            end
            crt_pkg::S_DSTEP: begin
                if (r_phase == crt_pkg::PH_COEF) begin
                    n_coef[r_i] = r_a;
                    if ({1'b0, r_i} + 4'd1 < {1'b0, w_n}) begin
                        n_i     = r_i + 3'd1;
                        n_phase = crt_pkg::PH_PART;
                        n_j     = '0;
                        n_a     = RW'(1);
                        n_b     = mod_eff(r_mod[0]);
                        n_state = crt_pkg::S_DMUL;
                    end else begin
                        n_state = crt_pkg::S_IDLE;
                    end
                end else if ({1'b0, r_j} + 4'd1 < {1'b0, w_n}) begin
                    n_j = r_j + 3'd1;
                    if (r_phase == crt_pkg::PH_PART && (r_j + 3'd1) == r_i) begin
                        n_b = MW'(1);
                    end else begin
                        n_b = mod_eff(r_mod[r_j + 3'd1]);
                    end
                    n_state = crt_pkg::S_DMUL;
                end else if (r_phase == crt_pkg::PH_Q) begin
                    n_q     = r_a;
                    n_phase = crt_pkg::PH_PART;
                    n_i     = '0;
                    n_j     = '0;
                    n_a     = RW'(1);
                    n_b     = MW'(1);
                    n_state = crt_pkg::S_DMUL;
                end else begin
                    n_dr    = '0;
                    n_bit   = '0;
                    n_state = crt_pkg::S_DRED;
                end
            end
            crt_pkg::S_DRED: begin
                // rotate so the partial product is back in place after a full pass
                t13   = {r_dr, r_a[RW-1]};
                n_dr  = (t13 >= {1'b0, mi}) ? MW'(t13 - {1'b0, mi}) : t13[MW-1:0];
                n_a   = {r_a[RW-2:0], r_a[RW-1]};
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'(RW-1)) begin
                    n_r0    = n_dr;
                    n_r1    = mi;
                    n_s0    = 14'sd1;
                    n_s1    = 14'sd0;
                    n_state = crt_pkg::S_EUC;
                end
            end
            crt_pkg::S_EUC: begin
                if (r_r1 == '0) begin
                    if (r_s0 < 0) begin
                        inv = r_s0 + m14;
                    end else if (r_s0 >= m14) begin
                        inv = r_s0 - m14;
                    end else begin
                        inv = r_s0;
                    end
                    n_b     = inv[MW-1:0];
                    n_p     = '0;
                    n_bit   = '0;
                    n_phase = crt_pkg::PH_COEF;
                    n_state = crt_pkg::S_DMUL;
                end else begin
                    n_dq    = r_r0;
                    n_dr    = '0;
                    n_bit   = '0;
                    n_state = crt_pkg::S_EDIV;
                end
            end
            crt_pkg::S_EDIV: begin
                t13   = {r_dr, r_dq[MW-1]};
                n_dr  = (t13 >= {1'b0, r_r1}) ? MW'(t13 - {1'b0, r_r1}) : t13[MW-1:0];
                n_dq  = {r_dq[MW-2:0], (t13 >= {1'b0, r_r1})};
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'(MW-1)) begin
                    n_state = crt_pkg::S_EUPD;
                end
            end
            crt_pkg::S_EUPD: begin
                prod    = $signed({1'b0, r_dq}) * r_s1;
                n_r0    = r_r1;
                n_r1    = r_dr;
                n_s0    = r_s1;
                n_s1    = 14'(r_s0 - prod);
                n_state = crt_pkg::S_EUC;
            end
            crt_pkg::S_RED: begin
                n_p   = w_rout;
                n_v   = {r_v[VW-2:0], 1'b0};
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'(VW-1)) begin
                    n_a   = w_rout;
                    n_p   = '0;
                    n_bit = '0;
                    n_sub = 1'b0;
                    if (!r_mode) begin
                        n_alpha = r_coef[r_cnt_el];
                        n_state = crt_pkg::S_PMUL;
                    end else begin
                        for (int k = 0; k < ND; k++) begin
                            n_lane[k] = '0;
                        end
                        n_state = crt_pkg::S_ULANE;
                    end
                end
            end
            crt_pkg::S_PMUL: begin
                // double on the first half step, conditional add on the second
                n_sub = !r_sub;
                if (!r_sub) begin
                    n_p = w_rout;
                end else begin
                    if (r_alpha[RW-1]) begin
                        n_p = w_rout;
                    end
                    n_alpha = {r_alpha[RW-2:0], 1'b0};
                    n_bit   = r_bit + 6'd1;
                    if (r_bit == 6'(RW-1)) begin
                        n_state = crt_pkg::S_PSUM;
                    end
                end
            end
            crt_pkg::S_PSUM: begin
                if (r_cnt_el + 3'd1 == w_n) begin
                    n_p      = w_rout;
                    n_sum    = '0;
                    n_cnt_el = '0;
                    n_state  = crt_pkg::S_EMIT;
                end else begin
                    n_sum    = w_rout;
                    n_cnt_el = r_cnt_el + 3'd1;
                    n_state  = crt_pkg::S_IDLE;
                end
            end
            crt_pkg::S_ULANE: begin
                for (int k = 0; k < ND; k++) begin
                    t13 = {r_lane[k], r_a[RW-1]};
                    if (t13 >= {1'b0, mod_eff(r_mod[k])}) begin
                        n_lane[k] = MW'(t13 - {1'b0, mod_eff(r_mod[k])});
                    end else begin
                        n_lane[k] = t13[MW-1:0];
                    end
                end
                n_a   = {r_a[RW-2:0], 1'b0};
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'(RW-1)) begin
                    n_slot  = '0;
                    n_state = crt_pkg::S_EMIT;
                end
            end
            crt_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    if (!r_mode) begin
                        n_out.kind      = 1'b0;
                        n_out.slot      = '0;
                        n_out.result    = r_p;
                        n_out.final_res = 1'b1;
                        n_state         = crt_pkg::S_IDLE;
                    end else begin
                        n_out.kind      = 1'b1;
                        n_out.slot      = r_slot;
                        n_out.result    = {{(RW-MW){1'b0}}, r_lane[r_slot]};
                        n_out.final_res = (r_slot + 3'd1 == w_n);
                        n_slot          = r_slot + 3'd1;
                        if (r_slot + 3'd1 == w_n) begin
                            n_state = crt_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: n_state = crt_pkg::S_IDLE;
        endcase

        if (w_cfg_wr) begin
            if (w_cfg_idx < 3'(ND)) begin
                n_mod[w_cfg_idx] = pwdata[MW-1:0];
                n_state          = crt_pkg::S_DSTART;
            end else if (w_cfg_idx == crt_pkg::REG_DIMS) begin
                n_dims  = pwdata[2:0];
                n_state = crt_pkg::S_DSTART;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= crt_pkg::S_DSTART;
            r_phase  <= crt_pkg::PH_Q;
            r_mod[0] <= 12'd163;
            r_mod[1] <= 12'd167;
            r_mod[2] <= 12'd173;
            r_mod[3] <= 12'd179;
            r_mod[4] <= 12'd181;
            r_dims   <= 3'd5;
            r_sum    <= '0;
            r_cnt_el <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_mod    <= n_mod;
            r_dims   <= n_dims;
            r_sum    <= n_sum;
            r_cnt_el <= n_cnt_el;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q     <= n_q;
        r_coef  <= n_coef;
        r_i     <= n_i;
        r_j     <= n_j;
        r_a     <= n_a;
        r_b     <= n_b;
        r_p     <= n_p;
        r_bit   <= n_bit;
        r_r0    <= n_r0;
        r_r1    <= n_r1;
        r_s0    <= n_s0;
        r_s1    <= n_s1;
        r_dq    <= n_dq;
        r_dr    <= n_dr;
        r_v     <= n_v;
        r_mode  <= n_mode;
        r_lane  <= n_lane;
        r_sub   <= n_sub;
        r_alpha <= n_alpha;
        r_slot  <= n_slot;
        r_out   <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("core took a word and did not go busy");

    a_packed_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.kind) |-> (o_out_data.slot == 3'd0 && o_out_data.final_res))
        else $error("packed word with bad slot or final flag");

    a_packed_below_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.kind) |-> (o_out_data.result < r_q))
        else $error("packed word not reduced mod Q");
`endif

endmodule
`default_nettype wire
